// ===== rtl/polyline_length_accumulator_unit_defines.svh =====
// Assertion macros for the polyline length accumulator.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef POLYLINE_LENGTH_ACCUMULATOR_UNIT_DEFINES_SVH
`define POLYLINE_LENGTH_ACCUMULATOR_UNIT_DEFINES_SVH

`ifndef SYNTH
// The consequent holds in the same cycle as the antecedent.
`define PLAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define PLAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define PLAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/plau_pkg.sv =====
// Shared constants, types and tables of the polyline length accumulator.
// No dependencies; used by the channel interfaces and all modules.
`default_nettype none

package plau_pkg;

    // Field widths.
    localparam int COORD_WIDTH  = 32;
    localparam int LENGTH_WIDTH = 48;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    // Datapath widths.
    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SQ_W     = 66;
    localparam int RAD_W    = 68;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int CW       = 34;
    localparam int BAM_W    = 32;
    localparam int THETA_W  = 31;
    localparam int SEG_W    = 34;
    localparam int QUO_W    = 28;
    localparam int QUO_SHIFT = 39;
    localparam int REM_W6   = 6;
    localparam int SMALL_W  = 13;
    localparam int SMALL_SHIFT = 19;

    // Arithmetic constants.
    localparam logic [MUL_W-1:0] RECIP45       = 34'd12216795865;
    localparam logic [13:0]      RECIP45_SMALL = 14'd11651;
    localparam logic [CW-1:0]    KINV_Q30      = 34'd652032874;
    localparam logic [MUL_W-1:0] METRE16_TURN  = 34'd1280967324;
    localparam logic [60:0]      A_LIM         = 61'h1000_0000_0000_0000;
    localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = {LENGTH_WIDTH{1'b1}};

    // Request and status between the sequencer and the shared units.
    typedef struct packed {
        logic                 start;
        logic                 vector_mode;
        logic [BAM_W-1:0]     bam;
        logic signed [CW-1:0] vec_y;
        logic signed [CW-1:0] vec_x;
    } cordic_cmd_t;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] sin_q30;
        logic signed [CW-1:0] cos_q30;
        logic [THETA_W-1:0]   theta;
    } cordic_res_t;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } sqrt_cmd_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_res_t;

    // Arctangent of 2^-i as a binary angle, 2^32 per turn.
    function automatic logic [BAM_W-1:0] atan_bam(input logic [4:0] i);
        logic [BAM_W-1:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // Magnitude of a signed coordinate difference.
    function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] r;
        r = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        return r;
    endfunction

    // Magnitude of a signed CORDIC value.
    function automatic logic [CW-1:0] mag_cw(input logic signed [CW-1:0] v);
        logic [CW-1:0] r;
        r = v[CW-1] ? CW'(-v) : CW'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/plau_in_if.sv =====
// Point request channel: valid/ready handshake and the coordinate payload.
// Depends on plau_pkg for field widths.
`default_nettype none

interface plau_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [plau_pkg::COORD_WIDTH-1:0]    coord_x;
    logic signed [plau_pkg::COORD_WIDTH-1:0]    coord_y;
    logic                                       first_point;
    logic                                       last_point;

    modport source (output valid, output coord_x, output coord_y,
                    output first_point, output last_point, input ready);
    modport sink   (input valid, input coord_x, input coord_y,
                    input first_point, input last_point, output ready);
endinterface

`default_nettype wire

// ===== rtl/plau_out_if.sv =====
// Result request channel: valid/ready handshake and the length payload.
// Depends on plau_pkg for field widths.
`default_nettype none

interface plau_out_if;
    logic                               valid;
    logic                               ready;
    logic [plau_pkg::LENGTH_WIDTH-1:0]  path_length;
    logic                               length_nonzero;
    logic                               length_saturated;

    modport source (output valid, output path_length, output length_nonzero,
                    output length_saturated, input ready);
    modport sink   (input valid, input path_length, input length_nonzero,
                    input length_saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/plau_cordic.sv =====
// Iterative CORDIC unit: one micro-rotation per cycle, rotation or vectoring.
// Depends on plau_pkg for widths, the arctangent table and the request types.
`default_nettype none

module plau_cordic (
    input  wire                  clk,
    input  wire                  rst_n,
    input  plau_pkg::cordic_cmd_t cmd,
    output plau_pkg::cordic_res_t res
);
    import plau_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 vec_reg, vec_next;
    logic [1:0]           quad_reg, quad_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [CW-1:0] z_reg, z_next;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] ang;
    logic                 ccw;

    // One micro-rotation per cycle while busy.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        vec_next  = vec_reg;
        quad_next = quad_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        xs  = x_reg >>> cnt_reg;
        ys  = y_reg >>> cnt_reg;
        ang = CW'(atan_bam(5'(cnt_reg)));
        ccw = vec_reg ? !(y_reg > 0) : (z_reg >= 0);
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            vec_next  = cmd.vector_mode;
            quad_next = cmd.bam[BAM_W-1 -: 2];
            if (cmd.vector_mode)
            begin
                x_next = cmd.vec_x;
                y_next = cmd.vec_y;
                z_next = '0;
            end
            else
            begin
                x_next = KINV_Q30;
                y_next = '0;
                z_next = CW'(cmd.bam[BAM_W-3:0]);
            end
        end
        else if (busy_reg)
        begin
            if (ccw)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end
            if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        vec_reg  <= vec_next;
        quad_reg <= quad_next;
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // Quadrant mapping of the rotation result and clamping of the angle.
    always_comb
    begin
        res.done = done_reg;
        unique case (quad_reg)
            2'd0:
            begin
                res.cos_q30 = x_reg;
                res.sin_q30 = y_reg;
            end
            2'd1:
            begin
                res.cos_q30 = -y_reg;
                res.sin_q30 = x_reg;
            end
            2'd2:
            begin
                res.cos_q30 = -x_reg;
                res.sin_q30 = -y_reg;
            end
            default:
            begin
                res.cos_q30 = y_reg;
                res.sin_q30 = -x_reg;
            end
        endcase
        if (z_reg < 0)
            res.theta = '0;
        else if (z_reg > (CW'(1) <<< 30))
            res.theta = THETA_W'(1) << 30;
        else
            res.theta = z_reg[THETA_W-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/plau_isqrt.sv =====
// Iterative floor square root: one radicand bit pair per cycle.
// Depends on plau_pkg for widths and the request types.
`default_nettype none

module plau_isqrt (
    input  wire                 clk,
    input  wire                 rst_n,
    input  plau_pkg::sqrt_cmd_t cmd,
    output plau_pkg::sqrt_res_t res
);
    import plau_pkg::*;

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;

    logic [REM_W-1:0]    trial_rem;
    logic [REM_W-1:0]    trial_sub;
    logic                fits;

    // Restoring square root step.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        trial_rem = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial_sub = REM_W'({root_reg, 2'b01});
        fits      = trial_rem >= trial_sub;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = cmd.radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial_rem - trial_sub : trial_rem;
            root_next = {root_reg[ROOT_W-2:0], fits};
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            if (cnt_reg == CNT_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign res.done = done_reg;
    assign res.root = root_reg;

endmodule

`default_nettype wire

// ===== rtl/polyline_length_accumulator_unit.sv =====
// A new point is accepted only after the previous one has been accumulated, and after an
// end node only once its result has been registered; the result waits while an earlier
// one is still unaccepted. A geographic point takes four CORDIC rotations, two 34-step
// square roots and one CORDIC vectoring pass on the shared units.
// Reset (rst_n, asynchronous, active low) clears the previous point, the total, the
// saturation flag, the mode, the result valid and the sequencer; no clearing pass.
`default_nettype none
`include "polyline_length_accumulator_unit_defines.svh"

module polyline_length_accumulator_unit (
    input  wire       clk,
    input  wire       rst_n,
    input  wire       cfg_we,
    input  wire       cfg_wdata,
    plau_in_if.sink   point_ch,
    plau_out_if.source result_ch
);
    import plau_pkg::*;

    typedef enum logic [24:0] {
        S_IDLE     = 25'd1,
        S_DIFF     = 25'd2,
        S_P_SQX    = 25'd4,
        S_P_SQY    = 25'd8,
        S_P_SUM    = 25'd16,
        S_P_ROOT   = 25'd32,
        S_G_RECIP  = 25'd64,
        S_G_REM    = 25'd128,
        S_G_BAM    = 25'd256,
        S_G_ROT    = 25'd512,
        S_G_SH2    = 25'd1024,
        S_G_SL2    = 25'd2048,
        S_G_CC     = 25'd4096,
        S_G_T1     = 25'd8192,
        S_G_T2     = 25'd16384,
        S_G_A      = 25'd32768,
        S_G_SQA    = 25'd65536,
        S_G_SQA_W  = 25'd131072,
        S_G_SQB    = 25'd262144,
        S_G_SQB_W  = 25'd524288,
        S_G_ATAN   = 25'd1048576,
        S_G_ATAN_W = 25'd2097152,
        S_G_SCALE  = 25'd4194304,
        S_ACC      = 25'd8388608,
        S_EMIT     = 25'd16777216
    } state_t;

    state_t state_reg, state_next;

    logic                              mode_reg, mode_next;
    logic signed [COORD_WIDTH-1:0]     cur_x_reg, cur_x_next;
    logic signed [COORD_WIDTH-1:0]     cur_y_reg, cur_y_next;
    logic                              first_reg, first_next;
    logic                              last_reg, last_next;
    logic signed [COORD_WIDTH-1:0]     prev_x_reg, prev_x_next;
    logic signed [COORD_WIDTH-1:0]     prev_y_reg, prev_y_next;
    logic [LENGTH_WIDTH-1:0]           total_reg, total_next;
    logic                              clipped_reg, clipped_next;
    logic signed [DIFF_W-1:0]          dlon_reg, dlon_next;
    logic signed [DIFF_W-1:0]          dlat_reg, dlat_next;
    logic [1:0]                        ang_idx_reg, ang_idx_next;
    logic [QUO_W-1:0]                  quo_reg, quo_next;
    logic [REM_W6-1:0]                 rem_reg, rem_next;
    logic signed [CW-1:0]              c1_reg, c1_next;
    logic signed [CW-1:0]              c2_reg, c2_next;
    logic signed [CW-1:0]              sh_reg, sh_next;
    logic signed [CW-1:0]              sl_reg, sl_next;
    logic [SQ_W-1:0]                   sqa_reg, sqa_next;
    logic [SQ_W-1:0]                   sqb_reg, sqb_next;
    logic [31:0]                       pm_reg, pm_next;
    logic                              pneg_reg, pneg_next;
    logic [SQ_W-1:0]                   t1_reg, t1_next;
    logic [MUL_W-1:0]                  t2_reg, t2_next;
    logic [60:0]                       a_reg, a_next;
    logic [THETA_W-1:0]                sa_reg, sa_next;
    logic [THETA_W-1:0]                sb_reg, sb_next;
    logic [SEG_W-1:0]                  seg_reg, seg_next;
    logic                              out_valid_reg, out_valid_next;
    logic [LENGTH_WIDTH-1:0]           out_total_reg, out_total_next;
    logic                              out_nz_reg, out_nz_next;
    logic                              out_sat_reg, out_sat_next;

    cordic_cmd_t cordic_cmd;
    cordic_res_t cordic_res;
    sqrt_cmd_t   sqrt_cmd;
    sqrt_res_t   sqrt_res;

    logic [MUL_W-1:0]             mul_a;
    logic [MUL_W-1:0]             mul_b;
    logic [PROD_W-1:0]            mul_p;
    logic [PROD_W-1:0]            scale_sum;
    logic signed [DIFF_W-1:0]     cx_ext, cy_ext, px_ext, py_ext;
    logic signed [DIFF_W-1:0]     ang_sel;
    logic [DIFF_W-1:0]            ang_mag;
    logic [DIFF_W-1:0]            quo_times45;
    logic [SMALL_W-1:0]           small_num;
    logic [26:0]                  small_prod;
    logic [BAM_W-1:0]             bam_mag;
    logic [BAM_W-1:0]             bam;
    logic [SQ_W-1:0]              term2;
    logic signed [SQ_W:0]         a_raw;
    logic [LENGTH_WIDTH-1:0]      room;
    logic [LENGTH_WIDTH-1:0]      seg_ext;

    // Shared arithmetic units.
    plau_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cordic_cmd),
        .res   (cordic_res)
    );

    plau_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (sqrt_cmd),
        .res   (sqrt_res)
    );

    // Coordinate extension and angle selection for the degree conversion.
    always_comb
    begin
        cx_ext = {cur_x_reg[COORD_WIDTH-1], cur_x_reg};
        cy_ext = {cur_y_reg[COORD_WIDTH-1], cur_y_reg};
        px_ext = {prev_x_reg[COORD_WIDTH-1], prev_x_reg};
        py_ext = {prev_y_reg[COORD_WIDTH-1], prev_y_reg};
        unique case (ang_idx_reg)
            2'd0:    ang_sel = py_ext;
            2'd1:    ang_sel = cy_ext;
            2'd2:    ang_sel = dlat_reg;
            default: ang_sel = dlon_reg;
        endcase
        ang_mag = mag_diff(ang_sel);
    end

    // Degrees to binary angle: magnitude split as 45*quotient + remainder.
    always_comb
    begin
        quo_times45 = DIFF_W'(quo_reg) * DIFF_W'(45);
        small_num   = ang_idx_reg[1] ? (SMALL_W'({rem_reg, 6'b0}) + SMALL_W'(22))
                                     : (SMALL_W'({rem_reg, 7'b0}) + SMALL_W'(22));
        small_prod  = 27'(small_num) * 27'(RECIP45_SMALL);
        bam_mag     = (ang_idx_reg[1] ? BAM_W'({quo_reg, 6'b0}) : BAM_W'({quo_reg, 7'b0}))
                      + BAM_W'(small_prod[26:SMALL_SHIFT]);
        bam         = ang_sel[DIFF_W-1] ? BAM_W'(-bam_mag) : bam_mag;
    end

    // Haversine term before its clamping to the unit interval in Q60.
    always_comb
    begin
        term2 = t1_reg + SQ_W'(t2_reg);
        a_raw = pneg_reg ? ($signed({1'b0, sqa_reg}) - $signed({1'b0, term2}))
                         : ($signed({1'b0, sqa_reg}) + $signed({1'b0, term2}));
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_P_SQX:
            begin
                mul_a = MUL_W'(mag_diff(dlon_reg));
                mul_b = MUL_W'(mag_diff(dlon_reg));
            end
            S_P_SQY:
            begin
                mul_a = MUL_W'(mag_diff(dlat_reg));
                mul_b = MUL_W'(mag_diff(dlat_reg));
            end
            S_G_RECIP:
            begin
                mul_a = MUL_W'(ang_mag);
                mul_b = RECIP45;
            end
            S_G_SH2:
            begin
                mul_a = mag_cw(sh_reg);
                mul_b = mag_cw(sh_reg);
            end
            S_G_SL2:
            begin
                mul_a = mag_cw(sl_reg);
                mul_b = mag_cw(sl_reg);
            end
            S_G_CC:
            begin
                mul_a = mag_cw(c1_reg);
                mul_b = mag_cw(c2_reg);
            end
            S_G_T1:
            begin
                mul_a = sqb_reg[63:30];
                mul_b = MUL_W'(pm_reg);
            end
            S_G_T2:
            begin
                mul_a = MUL_W'(sqb_reg[29:0]);
                mul_b = MUL_W'(pm_reg);
            end
            S_G_SCALE:
            begin
                mul_a = MUL_W'(cordic_res.theta);
                mul_b = METRE16_TURN;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
        scale_sum = mul_p + (PROD_W'(1) << 31);
    end

    // Headroom and extended segment for the saturating accumulation.
    always_comb
    begin
        room    = LENGTH_MAX - total_reg;
        seg_ext = LENGTH_WIDTH'(seg_reg);
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = cfg_we ? cfg_wdata : mode_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        total_next     = total_reg;
        clipped_next   = clipped_reg;
        dlon_next      = dlon_reg;
        dlat_next      = dlat_reg;
        ang_idx_next   = ang_idx_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        sh_next        = sh_reg;
        sl_next        = sl_reg;
        sqa_next       = sqa_reg;
        sqb_next       = sqb_reg;
        pm_next        = pm_reg;
        pneg_next      = pneg_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        a_next         = a_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        out_total_next = out_total_reg;
        out_nz_next    = out_nz_reg;
        out_sat_next   = out_sat_reg;

        cordic_cmd.start       = 1'b0;
        cordic_cmd.vector_mode = 1'b0;
        cordic_cmd.bam         = bam;
        cordic_cmd.vec_y       = CW'(sa_reg);
        cordic_cmd.vec_x       = CW'(sb_reg);
        sqrt_cmd.start         = 1'b0;
        sqrt_cmd.radicand      = RAD_W'(a_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (point_ch.valid)
                begin
                    cur_x_next = point_ch.coord_x;
                    cur_y_next = point_ch.coord_y;
                    first_next = point_ch.first_point;
                    last_next  = point_ch.last_point;
                    state_next = point_ch.first_point ? S_ACC : S_DIFF;
                end
            end
            S_DIFF:
            begin
                dlon_next    = cx_ext - px_ext;
                dlat_next    = cy_ext - py_ext;
                ang_idx_next = '0;
                state_next   = mode_reg ? S_G_RECIP : S_P_SQX;
            end
            S_P_SQX:
            begin
                sqa_next   = mul_p[SQ_W-1:0];
                state_next = S_P_SQY;
            end
            S_P_SQY:
            begin
                sqb_next   = mul_p[SQ_W-1:0];
                state_next = S_P_SUM;
            end
            S_P_SUM:
            begin
                sqrt_cmd.start    = 1'b1;
                sqrt_cmd.radicand = RAD_W'(sqa_reg) + RAD_W'(sqb_reg);
                state_next        = S_P_ROOT;
            end
            S_P_ROOT:
            begin
                if (sqrt_res.done)
                begin
                    seg_next   = SEG_W'(sqrt_res.root);
                    state_next = S_ACC;
                end
            end
            S_G_RECIP:
            begin
                quo_next   = mul_p[QUO_SHIFT +: QUO_W];
                state_next = S_G_REM;
            end
            S_G_REM:
            begin
                rem_next   = REM_W6'(ang_mag - quo_times45);
                state_next = S_G_BAM;
            end
            S_G_BAM:
            begin
                cordic_cmd.start = 1'b1;
                state_next       = S_G_ROT;
            end
            S_G_ROT:
            begin
                if (cordic_res.done)
                begin
                    unique case (ang_idx_reg)
                        2'd0:    c1_next = cordic_res.cos_q30;
                        2'd1:    c2_next = cordic_res.cos_q30;
                        2'd2:    sh_next = cordic_res.sin_q30;
                        default: sl_next = cordic_res.sin_q30;
                    endcase
                    if (ang_idx_reg == 2'd3)
                    begin
                        state_next = S_G_SH2;
                    end
                    else
                    begin
                        ang_idx_next = ang_idx_reg + 1'b1;
                        state_next   = S_G_RECIP;
                    end
                end
            end
            S_G_SH2:
            begin
                sqa_next   = mul_p[SQ_W-1:0];
                state_next = S_G_SL2;
            end
            S_G_SL2:
            begin
                sqb_next   = mul_p[SQ_W-1:0];
                state_next = S_G_CC;
            end
            S_G_CC:
            begin
                pm_next    = mul_p[61:30];
                pneg_next  = c1_reg[CW-1] ^ c2_reg[CW-1];
                state_next = S_G_T1;
            end
            S_G_T1:
            begin
                t1_next    = mul_p[SQ_W-1:0];
                state_next = S_G_T2;
            end
            S_G_T2:
            begin
                t2_next    = mul_p[30 +: MUL_W];
                state_next = S_G_A;
            end
            S_G_A:
            begin
                if (a_raw[SQ_W])
                    a_next = '0;
                else if (a_raw > $signed({6'b0, A_LIM}))
                    a_next = A_LIM;
                else
                    a_next = a_raw[60:0];
                state_next = S_G_SQA;
            end
            S_G_SQA:
            begin
                sqrt_cmd.start = 1'b1;
                state_next     = S_G_SQA_W;
            end
            S_G_SQA_W:
            begin
                if (sqrt_res.done)
                begin
                    sa_next    = sqrt_res.root[THETA_W-1:0];
                    state_next = S_G_SQB;
                end
            end
            S_G_SQB:
            begin
                sqrt_cmd.start    = 1'b1;
                sqrt_cmd.radicand = RAD_W'(A_LIM - a_reg);
                state_next        = S_G_SQB_W;
            end
            S_G_SQB_W:
            begin
                if (sqrt_res.done)
                begin
                    sb_next    = sqrt_res.root[THETA_W-1:0];
                    state_next = S_G_ATAN;
                end
            end
            S_G_ATAN:
            begin
                cordic_cmd.start       = 1'b1;
                cordic_cmd.vector_mode = 1'b1;
                state_next             = S_G_ATAN_W;
            end
            S_G_ATAN_W:
            begin
                if (cordic_res.done)
                    state_next = S_G_SCALE;
            end
            S_G_SCALE:
            begin
                seg_next   = scale_sum[32 +: SEG_W];
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (first_reg)
                begin
                    total_next   = '0;
                    clipped_next = 1'b0;
                end
                else if (seg_ext > room)
                begin
                    total_next   = LENGTH_MAX;
                    clipped_next = 1'b1;
                end
                else
                begin
                    total_next = total_reg + seg_ext;
                end
                prev_x_next = cur_x_reg;
                prev_y_next = cur_y_reg;
                state_next  = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = total_reg;
                    out_nz_next    = total_reg != '0;
                    out_sat_next   = clipped_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            total_reg     <= '0;
            clipped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            total_reg     <= total_next;
            clipped_reg   <= clipped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        dlon_reg      <= dlon_next;
        dlat_reg      <= dlat_next;
        ang_idx_reg   <= ang_idx_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        c1_reg        <= c1_next;
        c2_reg        <= c2_next;
        sh_reg        <= sh_next;
        sl_reg        <= sl_next;
        sqa_reg       <= sqa_next;
        sqb_reg       <= sqb_next;
        pm_reg        <= pm_next;
        pneg_reg      <= pneg_next;
        t1_reg        <= t1_next;
        t2_reg        <= t2_next;
        a_reg         <= a_next;
        sa_reg        <= sa_next;
        sb_reg        <= sb_next;
        seg_reg       <= seg_next;
        out_total_reg <= out_total_next;
        out_nz_reg    <= out_nz_next;
        out_sat_reg   <= out_sat_next;
    end

    // Channel outputs.
    assign point_ch.ready             = (state_reg == S_IDLE);
    assign result_ch.valid            = out_valid_reg;
    assign result_ch.path_length      = out_total_reg;
    assign result_ch.length_nonzero   = out_nz_reg;
    assign result_ch.length_saturated = out_sat_reg;

    // Checks.
    `PLAU_ASSERT_IMPLY(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_reg),
        "sequencer state is not one-hot")
    `PLAU_ASSERT_NEXT(a_busy_after_request, clk, rst_n, point_ch.valid && point_ch.ready,
        !point_ch.ready, "point request accepted while a point is in work")
    `PLAU_ASSERT_IMPLY(a_clip_at_max, clk, rst_n, clipped_reg, total_reg == LENGTH_MAX,
        "saturation flag set with total below maximum")
    `PLAU_ASSERT_IMPLY(a_units_exclusive, clk, rst_n, cordic_res.done, !sqrt_res.done,
        "CORDIC and square root finished together")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for polyline_length_accumulator_unit: random and directed polylines
// in planar and geographic mode, checked against a bit-exact length predictor.
// Depends on plau_pkg, plau_in_if, plau_out_if and the unit itself.
`default_nettype none

module tb_top;
    import plau_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [LENGTH_WIDTH-1:0] TOTAL_MAX = {LENGTH_WIDTH{1'b1}};
    localparam longint Q30 = 64'sd1 << 30;
    localparam longint HAV_ONE = 64'sd1 << 60;
    localparam longint DEG = 64'sd1 << 22;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic first;
        logic last;
    } point_t;

    typedef struct {
        logic [LENGTH_WIDTH-1:0] length;
        logic nonzero;
        logic saturated;
    } total_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    plau_in_if  in_ch ();
    plau_out_if out_ch ();

    polyline_length_accumulator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .point_ch  (in_ch),
        .result_ch (out_ch)
    );

    point_t pending_points[$];
    total_t expected_totals[$];
    longint arctan_tab[32];
    int errors;
    int cycles;
    int send_gap;
    int recv_stall;
    bit hold_points;
    bit no_idle;

    // Predictor state: previous point, running total, clip flag and mode.
    longint prev_x;
    longint prev_y;
    logic [LENGTH_WIDTH-1:0] run_total;
    bit run_clipped;
    bit geo_mode;

    // Floor square root of a 128-bit value, one result bit per pass.
    function automatic logic [63:0] floor_root(input logic [127:0] v);
        logic [67:0] r;
        logic [67:0] t;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int k = 63; k >= 0; k--)
        begin
            r = (r << 2) | 68'(v[2*k +: 2]);
            t = {2'b00, q, 2'b01};
            q = q << 1;
            if (r >= t)
            begin
                r = r - t;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] plane_length(input longint dx, input longint dy);
        logic [127:0] ax;
        logic [127:0] ay;
        ax = 128'(dx < 0 ? -dx : dx);
        ay = 128'(dy < 0 ? -dy : dy);
        return floor_root(ax * ax + ay * ay);
    endfunction

    // Degrees * 2^22 scaled by mul/45 into a binary angle, rounded on the magnitude.
    function automatic logic [31:0] deg_to_angle(input longint v, input longint unsigned mul);
        longint unsigned m;
        longint unsigned q;
        m = longint'(v < 0 ? -v : v) * mul;
        q = (m + 22) / 45;
        if (v < 0)
            q = -q;
        return q[31:0];
    endfunction

    function automatic void rotate(input logic [31:0] ang, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = 64'sd652032874;
        y = 0;
        z = longint'({2'b00, ang[29:0]});
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - arctan_tab[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + arctan_tab[i];
            end
        end
        case (ang[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint vector_angle(input longint y, input longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys; y = y - xs; z = z + arctan_tab[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - arctan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > Q30) z = Q30;
        return z;
    endfunction

    // Haversine great-circle length in metres * 16.
    function automatic logic [63:0] sphere_length(input longint lon1, input longint lat1,
                                                   input longint lon2, input longint lat2);
        longint s1, c1, s2, c2, sh, ch, sl, cl, p, a;
        longint unsigned hsq, lsq, pm, term2, theta;
        rotate(deg_to_angle(lat1, 128), s1, c1);
        rotate(deg_to_angle(lat2, 128), s2, c2);
        rotate(deg_to_angle(lat2 - lat1, 64), sh, ch);
        rotate(deg_to_angle(lon2 - lon1, 64), sl, cl);
        hsq = longint'(sh < 0 ? -sh : sh);
        hsq = hsq * hsq;
        lsq = longint'(sl < 0 ? -sl : sl);
        lsq = lsq * lsq;
        p = c1 * c2;
        pm = longint'(p < 0 ? -p : p) >> 30;
        term2 = (lsq >> 30) * pm + (((lsq & 64'h3FFF_FFFF) * pm) >> 30);
        a = longint'(hsq) + (p < 0 ? -longint'(term2) : longint'(term2));
        if (a < 0) a = 0;
        if (a > HAV_ONE) a = HAV_ONE;
        theta = vector_angle(longint'(floor_root(128'(a))),
                             longint'(floor_root(128'(HAV_ONE - a))));
        return (theta * 64'd1280967324 + (64'd1 << 31)) >> 32;
    endfunction

    // Advance the predictor by one accepted point.
    task automatic predict_point(input point_t pt);
        longint x;
        longint y;
        logic [63:0] seg;
        total_t res;
        x = longint'(pt.x);
        y = longint'(pt.y);
        if (pt.first)
        begin
            run_total = '0;
            run_clipped = 1'b0;
        end
        else
        begin
            seg = geo_mode ? sphere_length(prev_x, prev_y, x, y)
                           : plane_length(x - prev_x, y - prev_y);
            if (seg > 64'(TOTAL_MAX - run_total))
            begin
                run_total = TOTAL_MAX;
                run_clipped = 1'b1;
            end
            else
                run_total = run_total + seg[LENGTH_WIDTH-1:0];
        end
        prev_x = x;
        prev_y = y;
        if (pt.last)
        begin
            res.length = run_total;
            res.nonzero = (run_total != 0);
            res.saturated = run_clipped;
            expected_totals.push_back(res);
        end
    endtask

    task automatic add_point(input longint x, input longint y, input bit f, input bit l);
        point_t pt;
        pt.x = COORD_WIDTH'(x);
        pt.y = COORD_WIDTH'(y);
        pt.first = f;
        pt.last = l;
        pending_points.push_back(pt);
    endtask

    // One random coordinate: wide, small, or within the valid degree ranges.
    function automatic longint pick_coord(input bit is_lat);
        case ($urandom_range(0, 3))
            0: return longint'($signed($urandom));
            1: return longint'($signed(32'($urandom_range(0, 2000)))) - 1000;
            default:
                if (is_lat)
                    return longint'($urandom_range(0, 180 * (1 << 22))) - 90 * DEG;
                else
                    return longint'($urandom_range(0, 360 * (1 << 22))) - 180 * DEG;
        endcase
    endfunction

    // Mostly complete polylines with random content, some loose points.
    task automatic add_random_points(input int count);
        int n;
        int v;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_point(pick_coord(1'b0), pick_coord(1'b1), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                n++;
            end
            else
            begin
                v = $urandom_range(0, 6);
                add_point(pick_coord(1'b0), pick_coord(1'b1), 1'b1,
                          v == 0 && $urandom_range(0, 1) != 0);
                for (int i = 0; i < v; i++)
                    add_point(pick_coord(1'b0), pick_coord(1'b1), 1'b0, i == v - 1);
                n += v + 1;
            end
        end
    endtask

    task automatic write_mode(input bit mode);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        geo_mode = mode;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until all points are sent and all expected totals seen, then let the unit settle.
    task automatic wait_idle();
        while (pending_points.size() != 0 || in_ch.valid || expected_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Request driver: present queued points with random gaps.
    always @(posedge clk)
    begin
        point_t nxt;
        int g;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_point('{in_ch.coord_x, in_ch.coord_y, in_ch.first_point,
                                in_ch.last_point});
                g = no_idle ? 0 : $urandom_range(0, 4);
                if (g == 0 && pending_points.size() != 0 && !hold_points)
                begin
                    nxt = pending_points.pop_front();
                    in_ch.coord_x <= nxt.x;
                    in_ch.coord_y <= nxt.y;
                    in_ch.first_point <= nxt.first;
                    in_ch.last_point <= nxt.last;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                    send_gap <= g;
                end
            end
            else if (!in_ch.valid)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (pending_points.size() != 0 && !hold_points)
                begin
                    nxt = pending_points.pop_front();
                    in_ch.coord_x <= nxt.x;
                    in_ch.coord_y <= nxt.y;
                    in_ch.first_point <= nxt.first;
                    in_ch.last_point <= nxt.last;
                    in_ch.valid <= 1'b1;
                end
            end
        end
    end

    // Result monitor: random stalls and field-by-field comparison.
    always @(posedge clk)
    begin
        total_t exp_t;
        int s;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_totals.size() == 0)
                begin
                    $display("%0t: unexpected total %0d", $time, out_ch.path_length);
                    errors++;
                end
                else
                begin
                    exp_t = expected_totals.pop_front();
                    if (out_ch.path_length !== exp_t.length)
                    begin
                        $display("%0t: path_length expected %0d actual %0d", $time,
                                 exp_t.length, out_ch.path_length);
                        errors++;
                    end
                    if (out_ch.length_nonzero !== exp_t.nonzero)
                    begin
                        $display("%0t: length_nonzero expected %0b actual %0b", $time,
                                 exp_t.nonzero, out_ch.length_nonzero);
                        errors++;
                    end
                    if (out_ch.length_saturated !== exp_t.saturated)
                    begin
                        $display("%0t: length_saturated expected %0b actual %0b", $time,
                                 exp_t.saturated, out_ch.length_saturated);
                        errors++;
                    end
                end
                s = no_idle ? 0 : $urandom_range(0, 4);
                if (s != 0)
                begin
                    out_ch.ready <= 1'b0;
                    recv_stall <= s;
                end
            end
            else if (!out_ch.ready)
            begin
                if (recv_stall <= 1)
                    out_ch.ready <= 1'b1;
                recv_stall <= recv_stall - 1;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus and phase sequencing.
    initial
    begin
        arctan_tab = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
            64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
            64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
            64'h00000001, 64'h00000000};
        errors = 0;
        cycles = 0;
        send_gap = 0;
        recv_stall = 0;
        hold_points = 1'b1;
        no_idle = 1'b0;
        prev_x = 0;
        prev_y = 0;
        run_total = '0;
        run_clipped = 1'b0;
        geo_mode = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.coord_x = '0;
        in_ch.coord_y = '0;
        in_ch.first_point = 1'b0;
        in_ch.last_point = 1'b0;
        out_ch.ready = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Planar directed: measuring from the origin, extremes, start and end together.
        write_mode(1'b0);
        add_point(-64'sd2147483648, -64'sd2147483648, 1'b0, 1'b1);
        add_point(64'sd2147483647, 64'sd2147483647, 1'b1, 1'b1);
        add_point(-64'sd2147483648, 64'sd2147483647, 1'b1, 1'b0);
        add_point(64'sd2147483647, -64'sd2147483648, 1'b0, 1'b0);
        add_point(-64'sd2147483648, -64'sd2147483648, 1'b0, 1'b1);
        add_point(3, 4, 1'b0, 1'b1);
        add_point(3, 4, 1'b0, 1'b1);
        add_point(0, 0, 1'b1, 1'b0);
        add_point(0, 0, 1'b0, 1'b1);
        hold_points = 1'b0;
        wait_idle();

        // Geographic directed: antipodes, poles, latitude beyond 90 degrees, wrap.
        write_mode(1'b1);
        add_point(0, 0, 1'b1, 1'b0);
        add_point(180 * DEG, 0, 1'b0, 1'b1);
        add_point(0, 90 * DEG, 1'b1, 1'b0);
        add_point(0, -90 * DEG, 1'b0, 1'b0);
        add_point(-180 * DEG, 135 * DEG, 1'b0, 1'b0);
        add_point(90 * DEG, -170 * DEG, 1'b0, 1'b1);
        add_point(-64'sd2147483648, 64'sd2147483647, 1'b0, 1'b0);
        add_point(64'sd2147483647, -64'sd2147483648, 1'b0, 1'b1);
        add_point(5, 5, 1'b1, 1'b1);
        add_point(6, 5, 1'b0, 1'b1);
        wait_idle();

        // Random phases alternating the mode; polylines may span a mode change.
        for (int ph = 0; ph < 8; ph++)
        begin
            no_idle = (ph == 3);
            add_random_points(215);
            wait_idle();
            write_mode(ph[0]);
        end
        no_idle = 1'b0;
        wait_idle();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
